>>> hdl/sscu_pkg.sv
// sscu_pkg: types, register codes and small tables for the scanline sprite compositor
// no dependencies; imported by every other file of the block

package sscu_pkg;

    localparam int DOTS_PER_LINE = 228;
    localparam int HBLANK_DOTS   = 68;
    localparam int VIS_COLS      = 160;
    localparam int VISIBLE_ROWS  = 256;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [5:0] A_VSYNC  = 6'h00;
    localparam logic [5:0] A_VBLANK = 6'h01;
    localparam logic [5:0] A_WSYNC  = 6'h02;
    localparam logic [5:0] A_RSYNC  = 6'h03;
    localparam logic [5:0] A_NUSIZ0 = 6'h04;
    localparam logic [5:0] A_NUSIZ1 = 6'h05;
    localparam logic [5:0] A_COLUP0 = 6'h06;
    localparam logic [5:0] A_COLUBK = 6'h09;
    localparam logic [5:0] A_CTRLPF = 6'h0A;
    localparam logic [5:0] A_REFP0  = 6'h0B;
    localparam logic [5:0] A_REFP1  = 6'h0C;
    localparam logic [5:0] A_PF0    = 6'h0D;
    localparam logic [5:0] A_PF1    = 6'h0E;
    localparam logic [5:0] A_PF2    = 6'h0F;
    localparam logic [5:0] A_RESP0  = 6'h10;
    localparam logic [5:0] A_RESP1  = 6'h11;
    localparam logic [5:0] A_RESM0  = 6'h12;
    localparam logic [5:0] A_RESBL  = 6'h14;
    localparam logic [5:0] A_AUD_LO = 6'h15;
    localparam logic [5:0] A_AUD_HI = 6'h1A;
    localparam logic [5:0] A_GRP0   = 6'h1B;
    localparam logic [5:0] A_GRP1   = 6'h1C;
    localparam logic [5:0] A_ENAM0  = 6'h1D;
    localparam logic [5:0] A_ENAM1  = 6'h1E;
    localparam logic [5:0] A_ENABL  = 6'h1F;
    localparam logic [5:0] A_HMP0   = 6'h20;
    localparam logic [5:0] A_HMBL   = 6'h24;
    localparam logic [5:0] A_VDELP0 = 6'h25;
    localparam logic [5:0] A_VDELP1 = 6'h26;
    localparam logic [5:0] A_VDELBL = 6'h27;
    localparam logic [5:0] A_RESMP0 = 6'h28;
    localparam logic [5:0] A_RESMP1 = 6'h29;
    localparam logic [5:0] A_HMOVE  = 6'h2A;
    localparam logic [5:0] A_HMCLR  = 6'h2B;
    localparam logic [5:0] A_CXCLR  = 6'h2C;

    localparam logic [5:0] R_INPT4  = 6'h0C;
    localparam logic [5:0] R_INPT5  = 6'h0D;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] fire0_level;
        logic [7:0] fire1_level;
    } t_in_item;

    typedef struct packed {
        logic       pixel_valid;
        logic [7:0] pixel_column;
        logic [7:0] pixel_row;
        logic [6:0] pixel_colour;
        logic [7:0] read_data;
        logic       line_end;
        logic       field_end;
        logic       cpu_halt;
        logic       audio_strobe;
    } t_out_item;

    // object state seen by the compositor
    typedef struct packed {
        logic [3:0][6:0] col;
        logic [7:0]      pfctl;
        logic [19:0]     pf;
        logic [3:0][7:0] grp;
        logic [4:0][7:0] pos;
        logic [1:0][7:0] nusiz;
        logic            refp0;
        logic            refp1;
        logic            vdelp0;
        logic            vdelp1;
        logic            vdelbl;
        logic            enam0;
        logic            enam1;
        logic            enbl_new;
        logic            enbl_old;
        logic            resmp0;
        logic            resmp1;
    } t_vid_state;

    function automatic logic [1:0] copy_num(input logic [2:0] mode);
        case (mode)
            3'd1, 3'd2, 3'd4: copy_num = 2'd2;
            3'd3, 3'd6:       copy_num = 2'd3;
            default:          copy_num = 2'd1;
        endcase
    endfunction

    function automatic logic [6:0] copy_gap(input logic [2:0] mode, input logic [1:0] c);
        copy_gap = 7'd0;
        if (c == 2'd1) begin
            case (mode)
                3'd1, 3'd3: copy_gap = 7'd16;
                3'd2, 3'd6: copy_gap = 7'd32;
                3'd4:       copy_gap = 7'd64;
                default:    copy_gap = 7'd0;
            endcase
        end else if (c == 2'd2) begin
            case (mode)
                3'd3:    copy_gap = 7'd32;
                3'd6:    copy_gap = 7'd64;
                default: copy_gap = 7'd0;
            endcase
        end
    endfunction

    // folds a position in -160..319 back into 0..159
    function automatic logic [7:0] wrap160(input logic signed [9:0] v);
        logic signed [9:0] t;
        t = v;
        if (v < 0) begin
            t = v + 10'sd160;
        end else if (v >= 10'sd160) begin
            t = v - 10'sd160;
        end
        wrap160 = t[7:0];
    endfunction

endpackage

>>> hdl/sscu_if.sv
// sscu_in_if / sscu_out_if: valid/ready channels carrying one item each
// depends on sscu_pkg

interface sscu_in_if import sscu_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface sscu_out_if import sscu_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

>>> hdl/sscu_draw.sv
// sscu_draw: combinational compositor for one visible column
// depends on sscu_pkg; gives the palette index and the collision bits to set

module sscu_draw import sscu_pkg::*; (
    input  t_vid_state i_vs,
    input  logic [7:0] i_px,
    output logic [6:0] o_colour,
    output logic [15:0] o_coll_set
);

    function automatic logic player_hit(input logic [7:0] px, input logic [7:0] pos,
                                        input logic [7:0] g, input logic [2:0] mode,
                                        input logic refl);
        logic [1:0] sh;
        logic       hit;
        logic signed [9:0] rel;
        logic [4:0] rb;
        logic [2:0] b;
        sh  = (mode == 3'd5) ? 2'd1 : (mode == 3'd7) ? 2'd2 : 2'd0;
        hit = 1'b0;
        for (int c = 0; c < 3; c++) begin
            if (2'(c) < copy_num(mode)) begin
                rel = $signed({2'b0, px}) - $signed({2'b0, pos})
                    - $signed({3'b0, copy_gap(mode, 2'(c))});
                if (rel >= 0 && rel < (10'sd8 <<< sh)) begin
                    rb = rel[4:0] >> sh;
                    b  = rb[2:0];
                    if (refl ? g[b] : g[3'd7 - b]) begin
                        hit = 1'b1;
                    end
                end
            end
        end
        return hit;
    endfunction

    function automatic logic missile_hit(input logic [7:0] px, input logic [7:0] pos,
                                         input logic [7:0] nusiz, input logic en);
        logic hit;
        logic signed [9:0] rel;
        hit = 1'b0;
        for (int c = 0; c < 3; c++) begin
            if (2'(c) < copy_num(nusiz[2:0])) begin
                rel = $signed({2'b0, px}) - $signed({2'b0, pos})
                    - $signed({3'b0, copy_gap(nusiz[2:0], 2'(c))});
                if (rel >= 0 && rel < (10'sd1 <<< nusiz[5:4])) begin
                    hit = 1'b1;
                end
            end
        end
        return hit && en;
    endfunction

    logic [5:0] pf_slot;
    logic [5:0] idx;
    logic       en_bl;
    logic signed [9:0] bl_rel;
    logic       p0, p1, m0, m1, bl, pf;
    logic [6:0] pfc;

    always_comb begin
        pf_slot = 6'(i_px >> 2);
        if (pf_slot < 6'd20) begin
            idx = pf_slot;
        end else if (i_vs.pfctl[0]) begin
            idx = 6'd39 - pf_slot;
        end else begin
            idx = pf_slot - 6'd20;
        end
        pf     = i_vs.pf[idx[4:0]];
        en_bl  = i_vs.vdelbl ? i_vs.enbl_old : i_vs.enbl_new;
        bl_rel = $signed({2'b0, i_px}) - $signed({2'b0, i_vs.pos[4]});
        bl     = en_bl && bl_rel >= 0 && bl_rel < (10'sd1 <<< i_vs.pfctl[5:4]);
        p0 = player_hit(i_px, i_vs.pos[0], i_vs.vdelp0 ? i_vs.grp[1] : i_vs.grp[0],
                        i_vs.nusiz[0][2:0], i_vs.refp0);
        p1 = player_hit(i_px, i_vs.pos[1], i_vs.vdelp1 ? i_vs.grp[3] : i_vs.grp[2],
                        i_vs.nusiz[1][2:0], i_vs.refp1);
        m0 = missile_hit(i_px, i_vs.pos[2], i_vs.nusiz[0], i_vs.enam0 && !i_vs.resmp0);
        m1 = missile_hit(i_px, i_vs.pos[3], i_vs.nusiz[1], i_vs.enam1 && !i_vs.resmp1);

        o_coll_set = {p0 && p1, m0 && m1, bl && pf, 1'b0,
                      m1 && pf, m1 && bl, m0 && pf, m0 && bl,
                      p1 && pf, p1 && bl, p0 && pf, p0 && bl,
                      m1 && p0, m1 && p1, m0 && p1, m0 && p0};

        pfc = i_vs.pfctl[1] ? ((i_px < 8'd80) ? i_vs.col[0] : i_vs.col[1]) : i_vs.col[2];
        if (i_vs.pfctl[2]) begin
            if (pf || bl)    o_colour = bl ? i_vs.col[2] : pfc;
            else if (p0 || m0) o_colour = i_vs.col[0];
            else if (p1 || m1) o_colour = i_vs.col[1];
            else             o_colour = i_vs.col[3];
        end else begin
            if (p0 || m0)    o_colour = i_vs.col[0];
            else if (p1 || m1) o_colour = i_vs.col[1];
            else if (pf || bl) o_colour = bl ? i_vs.col[2] : pfc;
            else             o_colour = i_vs.col[3];
        end
    end

endmodule

>>> hdl/scanline_sprite_compositor_unit.sv
// scanline_sprite_compositor_unit: top level, register file, beam counters and result stage
// depends on sscu_pkg, sscu_if and sscu_draw
//
// usage
//   i_item carries one item per handshake: a dot tick, a register write or a register read.
//   o_result returns exactly one item for every accepted input item, in order.
//   an accepted item is held in an input register; while it waits there the register file,
//   counters and compositor resolve it and, once the result stage can advance, the result
//   register captures the answer. one item per cycle is sustained while o_result.ready
//   stays high, limited by the single state update per cycle.
//   i_item.ready stays high while the input register is empty or its item moves on, so
//   a stalled receiver holds the result and the one pending item, then input stops.
//   reset (i_rst_n low at a clock edge) clears the counters, every object register,
//   the collision latches and the halt request, and empties both stages.
//   a dot tick on a visible column outside sync and blank gives a pixel; the row
//   counter stops one past the last visible row until vertical sync ends.

module scanline_sprite_compositor_unit import sscu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sscu_in_if.sink     i_item,
    sscu_out_if.source  o_result
);

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;

    logic [7:0] r_dot, n_dot;
    logic [8:0] r_row, n_row;
    logic       r_sync, n_sync;
    logic       r_blank, n_blank;
    t_vid_state r_vs, n_vs;
    logic [4:0][3:0] r_mot, n_mot;
    logic [15:0] r_coll, n_coll;
    logic       r_halt, n_halt;

    logic       adv;
    logic       fire;
    logic [7:0] px;
    logic       active;
    logic [6:0] draw_colour;
    logic [15:0] draw_coll;
    t_out_item  res;

    assign adv            = !r_out_valid || o_result.ready;
    assign fire           = r_in_valid && adv;
    assign i_item.ready   = !r_in_valid || adv;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;
    assign px             = r_dot - 8'(HBLANK_DOTS);
    assign active         = !r_sync && !r_blank && (r_row < 9'(VISIBLE_ROWS));

    sscu_draw u_draw (
        .i_vs       (r_vs),
        .i_px       (px),
        .o_colour   (draw_colour),
        .o_coll_set (draw_coll)
    );

    always_comb begin
        n_dot   = r_dot;
        n_row   = r_row;
        n_sync  = r_sync;
        n_blank = r_blank;
        n_vs    = r_vs;
        n_mot   = r_mot;
        n_coll  = r_coll;
        n_halt  = r_halt;
        res     = '0;
        if (fire) begin
            case (r_in.func)
                FUNC_TICK: begin
                    if (r_dot >= 8'(HBLANK_DOTS) && active) begin
                        res.pixel_valid  = 1'b1;
                        res.pixel_column = px;
                        res.pixel_row    = r_row[7:0];
                        res.pixel_colour = draw_colour;
                        n_coll           = r_coll | draw_coll;
                    end
                    if (r_dot == 8'(DOTS_PER_LINE - 1)) begin
                        n_dot        = 8'd0;
                        res.line_end = 1'b1;
                        n_halt       = 1'b0;
                        if (active) begin
                            n_row = r_row + 9'd1;
                        end
                    end else begin
                        n_dot = r_dot + 8'd1;
                    end
                end
                FUNC_WRITE: begin
                    case (r_in.reg_addr) inside
                        A_VSYNC: begin
                            if (r_in.write_data[1] && !r_sync) res.field_end = 1'b1;
                            if (!r_in.write_data[1] && r_sync) n_row = 9'd0;
                            n_sync = r_in.write_data[1];
                        end
                        A_VBLANK: n_blank = r_in.write_data[1];
                        A_WSYNC:  n_halt = 1'b1;
                        A_RSYNC:  n_dot = 8'd0;
                        [A_NUSIZ0:A_NUSIZ1]:
                            n_vs.nusiz[r_in.reg_addr[0]] = r_in.write_data;
                        [A_COLUP0:A_COLUBK]:
                            n_vs.col[2'(r_in.reg_addr - A_COLUP0)] = r_in.write_data[7:1];
                        A_CTRLPF: n_vs.pfctl = r_in.write_data;
                        A_REFP0:  n_vs.refp0 = r_in.write_data[3];
                        A_REFP1:  n_vs.refp1 = r_in.write_data[3];
                        A_PF0:    n_vs.pf[3:0] = r_in.write_data[7:4];
                        A_PF1: begin
                            for (int i = 0; i < 8; i++) begin
                                n_vs.pf[4 + i] = r_in.write_data[7 - i];
                            end
                        end
                        A_PF2:    n_vs.pf[19:12] = r_in.write_data;
                        [A_RESP0:A_RESP1]:
                            n_vs.pos[3'(r_in.reg_addr - A_RESP0)] =
                                wrap160($signed({2'b0, r_dot}) - 10'sd68 + 10'sd5);
                        [A_RESM0:A_RESBL]:
                            n_vs.pos[3'(r_in.reg_addr - A_RESP0)] =
                                wrap160($signed({2'b0, r_dot}) - 10'sd68 + 10'sd4);
                        [A_AUD_LO:A_AUD_HI]: res.audio_strobe = 1'b1;
                        A_GRP0: begin
                            n_vs.grp[0] = r_in.write_data;
                            n_vs.grp[3] = r_vs.grp[2];
                        end
                        A_GRP1: begin
                            n_vs.grp[2]   = r_in.write_data;
                            n_vs.grp[1]   = r_vs.grp[0];
                            n_vs.enbl_old = r_vs.enbl_new;
                        end
                        A_ENAM0:  n_vs.enam0 = r_in.write_data[1];
                        A_ENAM1:  n_vs.enam1 = r_in.write_data[1];
                        A_ENABL:  n_vs.enbl_new = r_in.write_data[1];
                        [A_HMP0:A_HMBL]:
                            n_mot[3'(r_in.reg_addr - A_HMP0)] = r_in.write_data[7:4];
                        A_VDELP0: n_vs.vdelp0 = r_in.write_data[0];
                        A_VDELP1: n_vs.vdelp1 = r_in.write_data[0];
                        A_VDELBL: n_vs.vdelbl = r_in.write_data[0];
                        A_RESMP0: begin
                            n_vs.resmp0 = r_in.write_data[1];
                            if (r_in.write_data[1])
                                n_vs.pos[2] = wrap160($signed({2'b0, r_vs.pos[0]}) + 10'sd3);
                        end
                        A_RESMP1: begin
                            n_vs.resmp1 = r_in.write_data[1];
                            if (r_in.write_data[1])
                                n_vs.pos[3] = wrap160($signed({2'b0, r_vs.pos[1]}) + 10'sd3);
                        end
                        A_HMOVE: begin
                            for (int i = 0; i < 5; i++) begin
                                n_vs.pos[i] = wrap160($signed({2'b0, r_vs.pos[i]})
                                                      - $signed({{6{r_mot[i][3]}}, r_mot[i]}));
                            end
                        end
                        A_HMCLR:  n_mot = '0;
                        A_CXCLR:  n_coll = '0;
                        default: ;
                    endcase
                end
                FUNC_READ: begin
                    if (r_in.reg_addr < 6'd8) begin
                        res.read_data = {r_coll[{r_in.reg_addr[2:0], 1'b1}],
                                         r_coll[{r_in.reg_addr[2:0], 1'b0}], 6'b0};
                    end else if (r_in.reg_addr == R_INPT4) begin
                        res.read_data = r_in.fire0_level;
                    end else if (r_in.reg_addr == R_INPT5) begin
                        res.read_data = r_in.fire1_level;
                    end
                end
                default: ;
            endcase
        end
        res.cpu_halt = n_halt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dot       <= '0;
            r_row       <= '0;
            r_sync      <= 1'b0;
            r_blank     <= 1'b0;
            r_vs        <= '0;
            r_mot       <= '0;
            r_coll      <= '0;
            r_halt      <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            r_dot   <= n_dot;
            r_row   <= n_row;
            r_sync  <= n_sync;
            r_blank <= n_blank;
            r_vs    <= n_vs;
            r_mot   <= n_mot;
            r_coll  <= n_coll;
            r_halt  <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.data;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    a_dot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot < 8'(DOTS_PER_LINE))
        else $error("dot counter out of range");

    a_row_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= 9'(VISIBLE_ROWS))
        else $error("row counter past last visible row");

    a_cxclr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.func == FUNC_WRITE && r_in.reg_addr == A_CXCLR |=> r_coll == '0)
        else $error("collision latches not cleared");

    a_pixel_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.pixel_valid |-> r_out.pixel_column < 8'(VIS_COLS))
        else $error("pixel column beyond visible line");

    a_wrap_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.func == FUNC_TICK && r_dot == 8'(DOTS_PER_LINE - 1) |=> !r_halt)
        else $error("halt request survived line wrap");

endmodule
